@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Field widths, operation and status codes, and the per-beat control bundle
// broadcast from the top level to every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    // default sizing
    localparam int DEPTH_DEF    = 64;
    localparam int TAG_BITS_DEF = 16;

    // fixed field widths
    localparam int URG_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_TAG_W = 16;
    localparam int OCC_W     = 7;

    // operation codes carried in s_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // status codes carried in m_tuser
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // control broadcast to all cells for one beat
    typedef struct packed {
        logic             ins;   // insert the new entry this cycle
        logic             rem;   // pop the head this cycle
        logic [URG_W-1:0] urg;   // urgency of the new entry
    } spq_ctrl_t;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds an urgency and a tag; on insert it keeps, takes the new entry or takes
// its left neighbor's entry; on remove it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int INDEX    = 0,
    parameter int CNT_W    = 7,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  logic                       aclk,
    input  spq_pkg::spq_ctrl_t         ctrl,
    input  logic [TAG_BITS-1:0]        new_tag,
    input  logic [CNT_W-1:0]           count,
    input  logic                       prev_move,
    input  logic [spq_pkg::URG_W-1:0]  prev_urg,
    input  logic [TAG_BITS-1:0]        prev_tag,
    input  logic [spq_pkg::URG_W-1:0]  next_urg,
    input  logic [TAG_BITS-1:0]        next_tag,
    output logic                       move,
    output logic [spq_pkg::URG_W-1:0]  urg,
    output logic [TAG_BITS-1:0]        tag
);
    import spq_pkg::*;

    logic [URG_W-1:0]    urg_reg, urg_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                occupied;

    // slot is occupied when it lies below the fill count
    assign occupied = count > CNT_W'(INDEX);

    // entry here must shift right if the new entry belongs at or before it
    assign move = !occupied || (urg_reg > ctrl.urg);

    // select the slot contents for the next cycle
    always_comb begin
        urg_next = urg_reg;
        tag_next = tag_reg;
        if (ctrl.ins) begin
            if (prev_move) begin
                urg_next = prev_urg;
                tag_next = prev_tag;
            end else if (move) begin
                urg_next = ctrl.urg;
                tag_next = new_tag;
            end
        end else if (ctrl.rem) begin
            urg_next = next_urg;
            tag_next = next_tag;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        urg_reg <= urg_next;
        tag_reg <= tag_next;
    end

    assign urg = urg_reg;
    assign tag = tag_reg;

endmodule

@@ design/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue in a row of sorted cells
// Inserts keep arrival order among equal urgencies; removes pop the head.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat is one operation. s_tuser selects insert or remove;
//   s_tdata carries urgency and tag of an inserted entry (ignored on remove).
//   m_ channel: one result beat per operation, in order. m_tuser holds the
//   status (ok, full on insert, empty on remove); m_tdata holds the removed
//   tag and urgency (zero unless a remove succeeded) and the occupancy left.
//   Latency: the result is valid the cycle after the operation beat.
//   Throughput: one operation per cycle while the result side does not stall.
//   Every cell compares its urgency with the new entry and shifts in one step,
//   so the whole row updates at once; the output register is the only stage.
//   Reset: aresetn clears the fill count and the output valid; slot contents
//   are not cleared and never read before being written.
//   Stall: while a result waits with m_tready low, s_tready stays low and the
//   queue holds; when the result is taken a new beat may enter that cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter  int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter  int TAG_BITS = spq_pkg::TAG_BITS_DEF,
    localparam int S_DATA_W = ((spq_pkg::URG_W + TAG_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((spq_pkg::OUT_TAG_W + spq_pkg::URG_W
                                + spq_pkg::OCC_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_DATA_W-1:0]           s_tdata,   // urgency, tag, zero pad
    input  logic                          s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_DATA_W-1:0]           m_tdata,   // out_tag, out_urgency, occupancy, zero pad
    output logic [spq_pkg::STATUS_W-1:0]  m_tuser    // status
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PAD_W = M_DATA_W - OUT_TAG_W - URG_W - OCC_W;

    logic                 accept;
    logic                 full, empty;
    logic [URG_W-1:0]     in_urg;
    logic [TAG_BITS-1:0]  in_tag;
    spq_ctrl_t            ctrl;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [OUT_TAG_W-1:0] otag_reg, otag_next;
    logic [URG_W-1:0]     ourg_reg, ourg_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic                 move_w [DEPTH];
    logic [URG_W-1:0]     urg_w  [DEPTH];
    logic [TAG_BITS-1:0]  tag_w  [DEPTH];

    // input unpacking and handshake
    assign in_urg   = s_tdata[URG_W-1:0];
    assign in_tag   = s_tdata[URG_W +: TAG_BITS];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    // broadcast control to the row
    always_comb begin
        ctrl.ins = accept && (s_tuser == FUNC_INSERT) && !full;
        ctrl.rem = accept && (s_tuser == FUNC_REMOVE) && !empty;
        ctrl.urg = in_urg;
    end

    // row of slots
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                prev_move;
        logic [URG_W-1:0]    prev_urg, next_urg;
        logic [TAG_BITS-1:0] prev_tag, next_tag;

        if (i == 0) begin : g_first
            assign prev_move = 1'b0;
            assign prev_urg  = '0;
            assign prev_tag  = '0;
        end else begin : g_mid
            assign prev_move = move_w[i-1];
            assign prev_urg  = urg_w[i-1];
            assign prev_tag  = tag_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_urg = '0;
            assign next_tag = '0;
        end else begin : g_inner
            assign next_urg = urg_w[i+1];
            assign next_tag = tag_w[i+1];
        end

        spq_cell #(
            .INDEX    (i),
            .CNT_W    (CNT_W),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .new_tag   (in_tag),
            .count     (count_reg),
            .prev_move (prev_move),
            .prev_urg  (prev_urg),
            .prev_tag  (prev_tag),
            .next_urg  (next_urg),
            .next_tag  (next_tag),
            .move      (move_w[i]),
            .urg       (urg_w[i]),
            .tag       (tag_w[i])
        );
    end

    // fill count and result beat
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        otag_next    = otag_reg;
        ourg_next    = ourg_reg;
        occ_next     = occ_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            otag_next    = '0;
            ourg_next    = '0;
            if (ctrl.ins) begin
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_OK;
            end else if (ctrl.rem) begin
                count_next  = count_reg - CNT_W'(1);
                status_next = ST_OK;
                otag_next   = OUT_TAG_W'(tag_w[0]);
                ourg_next   = urg_w[0];
            end else if (s_tuser == FUNC_INSERT) begin
                status_next = ST_FULL;
            end else begin
                status_next = ST_EMPTY;
            end
            occ_next = OCC_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        otag_reg   <= otag_next;
        ourg_reg   <= ourg_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, occ_reg, ourg_reg, otag_reg};

endmodule

@@ tb/sv/stable_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_test: self-checking bench for the stable priority queue
// Streams insert and remove beats into the queue, predicts every result beat
// with a sorted shadow list, and compares each result field by field while
// both channels stall at random.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;

    import spq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int TAG_BITS    = 16;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 32;
    localparam int NUM_RANDOM  = 1450;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic               func;
        logic [URG_W-1:0]   urg;
        logic [TAG_BITS-1:0] tag;
    } queue_op_t;

    typedef struct packed {
        logic [URG_W-1:0]    urg;
        logic [TAG_BITS-1:0] tag;
    } queue_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_TAG_W-1:0] tag;
        logic [URG_W-1:0]     urg;
        logic [OCC_W-1:0]     occ;
    } queue_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // urgency, tag, zero pad
    logic                s_tuser  = 1'b0; // func
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // out_tag, out_urgency, occupancy, zero pad
    logic [STATUS_W-1:0] m_tuser;         // status

    queue_op_t     pending_ops[$];
    queue_entry_t  shadow_entries[$];
    queue_result_t expected_results[$];

    int total_ops;
    int sent_ops     = 0;
    int mismatches   = 0;
    int stall_cycles = 0;

    stable_priority_queue #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // apply one operation to the shadow list and return the result beat
    function automatic queue_result_t queue_step(queue_op_t op);
        queue_result_t r;
        int            pos;
        r = '0;
        if (op.func == FUNC_INSERT) begin
            if (shadow_entries.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind all entries of equal or more urgency
                pos = shadow_entries.size();
                while (pos > 0 && shadow_entries[pos-1].urg > op.urg)
                    pos--;
                shadow_entries.insert(pos, queue_entry_t'{op.urg, op.tag});
                r.status = ST_OK;
            end
        end else begin
            if (shadow_entries.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.tag    = shadow_entries[0].tag;
                r.urg    = shadow_entries[0].urg;
                void'(shadow_entries.pop_front());
                r.status = ST_OK;
            end
        end
        r.occ = OCC_W'(shadow_entries.size());
        return r;
    endfunction

    function automatic queue_op_t make_op(logic func, int urg, int tag);
        queue_op_t op;
        op.func = func;
        op.urg  = URG_W'(urg);
        op.tag  = TAG_BITS'(tag);
        return op;
    endfunction

    // idle percentage per phase: sender light then heavy, then none
    function automatic int sender_idle_pct(int sent);
        int phase;
        phase = (sent * 3) / total_ops;
        if (phase == 0) return 32;
        if (phase == 1) return 73;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int sent);
        int phase;
        phase = (sent * 3) / total_ops;
        if (phase == 0) return 73;
        if (phase == 1) return 32;
        return 0;
    endfunction

    // stimulus, reset and end of run
    initial begin
        int seg_len;
        int ins_pct;
        int n;

        // directed: empty remove, urgency and tag extremes, equal-urgency order
        pending_ops.push_back(make_op(FUNC_REMOVE, 3, 16'hffff));
        pending_ops.push_back(make_op(FUNC_INSERT, 3, 16'hffff));
        pending_ops.push_back(make_op(FUNC_INSERT, 0, 16'h0000));
        pending_ops.push_back(make_op(FUNC_INSERT, 1, 16'h1234));
        pending_ops.push_back(make_op(FUNC_INSERT, 1, 16'h1235));
        pending_ops.push_back(make_op(FUNC_INSERT, 0, 16'haaaa));
        pending_ops.push_back(make_op(FUNC_INSERT, 3, 16'h5555));
        pending_ops.push_back(make_op(FUNC_INSERT, 2, 16'h8001));
        pending_ops.push_back(make_op(FUNC_INSERT, 1, 16'h1236));
        for (int i = 0; i < 8; i++)
            pending_ops.push_back(make_op(FUNC_REMOVE, i % 4, 16'hc3c3 ^ i));
        pending_ops.push_back(make_op(FUNC_REMOVE, 0, 0));
        pending_ops.push_back(make_op(FUNC_REMOVE, 2, 16'h7fff));

        // random: segments biased to fill, drain or churn so full and empty recur
        n = 0;
        while (n < NUM_RANDOM) begin
            seg_len = $urandom_range(120, 40);
            case ($urandom_range(2))
                0: begin
                    ins_pct = 90;
                end
                1: begin
                    ins_pct = 10;
                end
                default: begin
                    ins_pct = 50;
                end
            endcase
            for (int i = 0; i < seg_len && n < NUM_RANDOM; i++) begin
                pending_ops.push_back(make_op(
                    ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE,
                    $urandom_range(3), $urandom_range(16'hffff)));
                n++;
            end
        end
        total_ops = pending_ops.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // drain everything, then let the output stage settle
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // driver: present the next pending op when the slot is free
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle_pct(sent_ops)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'({pending_ops[0].tag, pending_ops[0].urg});
                s_tuser  <= pending_ops[0].func;
                void'(pending_ops.pop_front());
                sent_ops <= sent_ops + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= receiver_idle_pct(sent_ops));
    end

    // monitor: predict on each input beat, check each result beat
    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        queue_op_t     op;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                op.func = s_tuser;
                op.urg  = s_tdata[URG_W-1:0];
                op.tag  = s_tdata[URG_W +: TAG_BITS];
                expected_results.push_back(queue_step(op));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.tag    = m_tdata[OUT_TAG_W-1:0];
                got.urg    = m_tdata[OUT_TAG_W +: URG_W];
                got.occ    = m_tdata[OUT_TAG_W + URG_W +: OCC_W];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d tag %h urg %0d occ %0d",
                                 got.status, got.tag, got.urg, got.occ);
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d tag %h urg %0d occ %0d,",
                                     want.status, want.tag, want.urg, want.occ,
                                     " got status %0d tag %h urg %0d occ %0d",
                                     got.status, got.tag, got.urg, got.occ);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", stall_cycles);
                $display("== FAIL ==");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
